FILE: hw/rtl/pointer_event_cooker_top_assert.svh
// ---------------------------------------------------------------------------
// Pointer event cooker assertion macros
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef POINTER_EVENT_COOKER_TOP_ASSERT_SVH
`define POINTER_EVENT_COOKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define PEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pointer event cooker check failed");
// Next-cycle implication, disabled while reset is asserted.
`define PEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pointer event cooker check failed");
`else
`define PEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/pec_pkg.sv
// ---------------------------------------------------------------------------
// Pointer event cooker package
// Shared codes, constants and the job record passed from front to back.
// ---------------------------------------------------------------------------
package pec_pkg;

	// Operation codes of an input item
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DOUBLE_WINDOW = 2'd0,
		REG_QUIET_TICKS   = 2'd1,
		REG_TICK_MS       = 2'd2
	} pec_reg_t;

	// Event kinds
	typedef enum logic [1:0] {
		KIND_PLAIN  = 2'd0,
		KIND_DOUBLE = 2'd1,
		KIND_QUIET  = 2'd2
	} pec_kind_t;

	localparam logic [15:0] PEC_DOUBLE_WINDOW_RST = 16'd500;
	localparam logic [3:0]  PEC_QUIET_TICKS_RST   = 4'd3;
	localparam logic [15:0] PEC_TICK_MS_RST       = 16'd500;
	localparam logic [4:0]  PEC_IDLE_MAX          = 5'd31;
	localparam logic [31:0] PEC_START_MS          = 32'd1;

	localparam int PEC_QUEUE_DEPTH = 4;

	// One job: an optional release of the previous sample, then the event itself.
	typedef struct packed {
		logic               has_rel;
		logic signed [15:0] rel_x;
		logic signed [15:0] rel_y;
		logic [31:0]        rel_ms;
		pec_kind_t          kind;
		logic [4:0]         buttons;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        ms;
	} pec_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pec_q_status_t;

endpackage

FILE: hw/rtl/pec_front.sv
// ---------------------------------------------------------------------------
// Pointer event cooker front end
// Accepts samples and ticks, keeps the pointer state and queues event jobs.
// ---------------------------------------------------------------------------
module pec_front import pec_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [4:0]         buttons,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [31:0]        stamp_ms,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  pec_q_status_t      q_status,
	output logic               push,
	output pec_job_t           push_job
);

	logic [15:0]        double_window_q;
	logic [3:0]         quiet_ticks_q;
	logic [15:0]        tick_ms_q;

	logic [4:0]         prev_buttons_q;
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic [31:0]        prev_ms_q;
	logic [31:0]        emitted_ms_q;
	logic [31:0]        quiet_ref_q;
	logic [4:0]         press_buttons_q;
	logic [31:0]        press_ms_q;
	logic               double_pending_q;
	logic [4:0]         idle_q;

	logic        accept;
	logic        is_sample;
	logic        dup;
	logic        release_first;
	logic        press;
	logic [31:0] press_delta;
	logic        double_hit;
	logic        double_now;
	logic        counting;
	logic [4:0]  idle_next;
	logic        quiet_fire;
	logic [31:0] quiet_stamp;

	assign in_stall  = q_status.full;
	assign accept    = in_valid && !in_stall;
	assign is_sample = (operation == OP_SAMPLE);

	always_comb begin
		dup = (pos_x == prev_x_q) && (pos_y == prev_y_q) && (buttons == prev_buttons_q);
		release_first = (prev_buttons_q != 5'd0) && (buttons != 5'd0)
			&& ((prev_buttons_q & buttons) == 5'd0);
		press       = (prev_buttons_q == 5'd0) && (buttons != 5'd0);
		press_delta = stamp_ms - press_ms_q;
		double_hit  = press && (buttons == press_buttons_q)
			&& (press_delta < {16'd0, double_window_q});
		double_now  = double_pending_q || double_hit;

		counting    = (prev_buttons_q == 5'd0) && (quiet_ref_q != 32'd0);
		idle_next   = (idle_q == PEC_IDLE_MAX) ? idle_q : idle_q + 5'd1;
		quiet_fire  = counting && (idle_next > {1'b0, quiet_ticks_q});
		// The quiet stamp lies two tick intervals after the last event.
		quiet_stamp = quiet_ref_q + {15'd0, tick_ms_q, 1'b0};

		push_job.has_rel = is_sample && release_first;
		push_job.rel_x   = prev_x_q;
		push_job.rel_y   = prev_y_q;
		push_job.rel_ms  = prev_ms_q;
		if (is_sample) begin
			push_job.kind    = double_now ? KIND_DOUBLE : KIND_PLAIN;
			push_job.buttons = buttons;
			push_job.x       = pos_x;
			push_job.y       = pos_y;
			push_job.ms      = stamp_ms;
		end else begin
			push_job.kind    = KIND_QUIET;
			push_job.buttons = prev_buttons_q;
			push_job.x       = prev_x_q;
			push_job.y       = prev_y_q;
			push_job.ms      = quiet_stamp;
		end

		push = accept && (is_sample ? !dup : quiet_fire);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_window_q <= PEC_DOUBLE_WINDOW_RST;
			quiet_ticks_q   <= PEC_QUIET_TICKS_RST;
			tick_ms_q       <= PEC_TICK_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DOUBLE_WINDOW: double_window_q <= cfg_data;
				REG_QUIET_TICKS:   quiet_ticks_q   <= cfg_data[3:0];
				REG_TICK_MS:       tick_ms_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q   <= 5'd0;
			prev_x_q         <= 16'sd0;
			prev_y_q         <= 16'sd0;
			prev_ms_q        <= 32'd0;
			emitted_ms_q     <= 32'd0;
			quiet_ref_q      <= PEC_START_MS;
			press_buttons_q  <= 5'd0;
			press_ms_q       <= 32'd0;
			double_pending_q <= 1'b0;
			idle_q           <= 5'd0;
		end else if (accept) begin
			if (is_sample) begin
				if (!dup) begin
					if (press) begin
						press_buttons_q <= buttons;
						press_ms_q      <= stamp_ms;
					end
					// A release carries the double flag and then clears it.
					double_pending_q <= (buttons == 5'd0) ? 1'b0 : double_now;
					emitted_ms_q     <= stamp_ms;
					quiet_ref_q      <= stamp_ms;
				end else begin
					quiet_ref_q <= emitted_ms_q;
				end
				prev_buttons_q <= buttons;
				prev_x_q       <= pos_x;
				prev_y_q       <= pos_y;
				prev_ms_q      <= stamp_ms;
				idle_q         <= 5'd0;
			end else if (prev_buttons_q != 5'd0) begin
				idle_q <= 5'd0;
			end else if (counting) begin
				idle_q <= idle_next;
				if (quiet_fire) begin
					emitted_ms_q <= quiet_stamp;
					quiet_ref_q  <= 32'd0;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/pec_queue.sv
// ---------------------------------------------------------------------------
// Pointer event cooker job queue
// Small first-in first-out store of jobs between the front and the back.
// ---------------------------------------------------------------------------
module pec_queue import pec_pkg::*; #(
	parameter int Depth = PEC_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pec_job_t      push_job,
	input  logic          pop,
	output pec_job_t      head_job,
	output pec_q_status_t status
);

	`include "pointer_event_cooker_top_assert.svh"

	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	pec_job_t        store_q [Depth];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign status.full  = (count_q == DepthCnt);
	assign status.empty = (count_q == '0);
	assign head_job     = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + IdxW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + IdxW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`PEC_ASSERT_SAME(a_no_push_full, clk, arst_n, push, !status.full)
	`PEC_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, !status.empty)

endmodule

FILE: hw/rtl/pec_back.sv
// ---------------------------------------------------------------------------
// Pointer event cooker back end
// Expands each job into one or two result items through an output register.
// ---------------------------------------------------------------------------
module pec_back import pec_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  pec_job_t           head_job,
	input  pec_q_status_t      q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic [4:0]         out_buttons,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [31:0]        out_ms,
	output logic               final_of_run
);

	`include "pointer_event_cooker_top_assert.svh"

	logic               valid_q;
	logic               rel_done_q;
	pec_kind_t          kind_q;
	logic [4:0]         buttons_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic [31:0]        ms_q;
	logic               final_q;

	logic slot_free;
	logic load;
	logic load_rel;

	assign slot_free = !valid_q || !out_stall;
	assign load      = slot_free && !q_status.empty;
	// The release copy goes out first and the job stays at the head.
	assign load_rel  = load && head_job.has_rel && !rel_done_q;
	assign pop       = load && !load_rel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			rel_done_q <= 1'b0;
		end else begin
			if (slot_free) begin
				valid_q <= load;
			end
			if (load_rel) begin
				rel_done_q <= 1'b1;
			end else if (pop) begin
				rel_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rel) begin
			kind_q    <= KIND_PLAIN;
			buttons_q <= 5'd0;
			x_q       <= head_job.rel_x;
			y_q       <= head_job.rel_y;
			ms_q      <= head_job.rel_ms;
			final_q   <= 1'b0;
		end else if (pop) begin
			kind_q    <= head_job.kind;
			buttons_q <= head_job.buttons;
			x_q       <= head_job.x;
			y_q       <= head_job.y;
			ms_q      <= head_job.ms;
			final_q   <= 1'b1;
		end
	end

	assign out_valid    = valid_q;
	assign event_kind   = kind_q;
	assign out_buttons  = buttons_q;
	assign out_x        = x_q;
	assign out_y        = y_q;
	assign out_ms       = ms_q;
	assign final_of_run = final_q;

	`PEC_ASSERT_SAME(a_rel_keeps_job, clk, arst_n, rel_done_q, !q_status.empty)
	`PEC_ASSERT_SAME(a_nonfinal_is_rel, clk, arst_n, valid_q && !final_q, rel_done_q)
	`PEC_ASSERT_NEXT(a_rel_then_main, clk, arst_n, load_rel, !load_rel)

endmodule

FILE: hw/rtl/pointer_event_cooker_top.sv
// ---------------------------------------------------------------------------
// Pointer event cooker
// Cleans pointer samples and timer ticks into plain, double-click and quiet
// events.
// ---------------------------------------------------------------------------
// The front end takes one item (sample or tick) every cycle while its job
// queue has room, updates the pointer state in that cycle and queues at most
// one job; duplicates and ticks that do not fire a quiet event leave nothing
// in the queue. The back end sends one result item per cycle while out_stall
// is low, through its output register, so a sample that first releases the
// previous button set yields two result items and any other event one. The
// queue holds QueueDepth jobs; in_stall rises only when it is full. A result
// item passes through the job queue and then the output register after its
// input item is accepted. Configuration writes take effect at the next edge
// and are meant for idle periods.
module pointer_event_cooker_top import pec_pkg::*; #(
	parameter int QueueDepth = PEC_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [4:0]         buttons,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [31:0]        stamp_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic [4:0]         out_buttons,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [31:0]        out_ms,
	output logic               final_of_run,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic          push;
	pec_job_t      push_job;
	logic          pop;
	pec_job_t      head_job;
	pec_q_status_t q_status;

	pec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.buttons   (buttons),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.stamp_ms  (stamp_ms),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.push      (push),
		.push_job  (push_job)
	);

	pec_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	pec_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.out_buttons  (out_buttons),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_ms       (out_ms),
		.final_of_run (final_of_run)
	);

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// Pointer event cooker testbench
// Drives pointer samples and timer ticks through the cooker under several
// register settings and random idling on both sides, predicts the cooked
// events in a scoreboard and checks every event field by field in order.
// ---------------------------------------------------------------------------
module testbench;
	import pec_pkg::*;

	localparam logic [1:0]  REG_SPARE         = 2'd3;
	localparam int          QUIET_STAMP_TICKS = 2;
	localparam int          SETTLE_CYCLES     = 8;
	localparam int          HALF_ITEMS        = 235;
	localparam int          HALVES            = 6;
	localparam longint      RUN_LIMIT         = 64'd12_000_000;

	typedef struct {
		pec_kind_t          kind;
		logic [4:0]         buttons;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        ms;
		logic               last_of_run;
	} cooked_t;

	// Mirrors the cooker state and holds the events still to come out.
	class event_forecast;
		logic [15:0]        double_window;
		logic [3:0]         quiet_limit;
		logic [15:0]        tick_interval;
		logic [4:0]         prev_buttons;
		logic signed [15:0] prev_x;
		logic signed [15:0] prev_y;
		logic [31:0]        prev_ms;
		logic [31:0]        emitted_ms;
		logic [31:0]        quiet_ref_ms;
		logic [4:0]         press_buttons;
		logic [31:0]        press_ms;
		logic               double_pending;
		logic [4:0]         idle_count;
		cooked_t            due_events[$];
		int                 errors;

		function new();
			double_window  = PEC_DOUBLE_WINDOW_RST;
			quiet_limit    = PEC_QUIET_TICKS_RST;
			tick_interval  = PEC_TICK_MS_RST;
			prev_buttons   = '0;
			prev_x         = '0;
			prev_y         = '0;
			prev_ms        = '0;
			emitted_ms     = '0;
			quiet_ref_ms   = PEC_START_MS;
			press_buttons  = '0;
			press_ms       = '0;
			double_pending = 1'b0;
			idle_count     = '0;
			errors         = 0;
		endfunction

		function void set_reg(logic [1:0] index, logic [15:0] data);
			case (index)
				REG_DOUBLE_WINDOW: double_window = data;
				REG_QUIET_TICKS:   quiet_limit   = data[3:0];
				REG_TICK_MS:       tick_interval = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_events.size();
		endfunction

		function void absorb_item(logic op, logic [4:0] b, logic signed [15:0] x,
				logic signed [15:0] y, logic [31:0] ms);
			cooked_t     ev;
			logic [31:0] stamp;
			if (op == OP_SAMPLE) begin
				if (!(x == prev_x && y == prev_y && b == prev_buttons)) begin
					// A jump straight to a disjoint set releases the old set first.
					if (prev_buttons != 0 && b != 0 && (prev_buttons & b) == 0) begin
						ev = '{KIND_PLAIN, 5'd0, prev_x, prev_y, prev_ms, 1'b0};
						due_events.push_back(ev);
					end
					if (prev_buttons == 0 && b != 0) begin
						stamp = ms - press_ms;
						if (b == press_buttons && stamp < {16'd0, double_window})
							double_pending = 1'b1;
						press_buttons = b;
						press_ms      = ms;
					end
					ev = '{double_pending ? KIND_DOUBLE : KIND_PLAIN, b, x, y, ms, 1'b1};
					if (b == 0)
						double_pending = 1'b0;
					due_events.push_back(ev);
					emitted_ms = ms;
				end
				quiet_ref_ms = emitted_ms;
				prev_buttons = b;
				prev_x       = x;
				prev_y       = y;
				prev_ms      = ms;
				idle_count   = '0;
			end else if (prev_buttons != 0) begin
				idle_count = '0;
			end else if (quiet_ref_ms != 0) begin
				if (idle_count < PEC_IDLE_MAX)
					idle_count++;
				if (idle_count > {1'b0, quiet_limit}) begin
					stamp = quiet_ref_ms + QUIET_STAMP_TICKS * {16'd0, tick_interval};
					ev = '{KIND_QUIET, prev_buttons, prev_x, prev_y, stamp, 1'b1};
					due_events.push_back(ev);
					emitted_ms   = stamp;
					quiet_ref_ms = '0;
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_event(logic [1:0] kind, logic [4:0] b, logic [15:0] x,
				logic [15:0] y, logic [31:0] ms, logic last);
			cooked_t ev;
			if (due_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual %0d %h %h %h %h %b",
					$time, kind, b, x, y, ms, last);
				errors++;
				return;
			end
			ev = due_events.pop_front();
			compare_field("event_kind", 32'(ev.kind), 32'(kind));
			compare_field("out_buttons", 32'(ev.buttons), 32'(b));
			compare_field("out_x", 32'($unsigned(ev.x)), 32'(x));
			compare_field("out_y", 32'($unsigned(ev.y)), 32'(y));
			compare_field("out_ms", ev.ms, ms);
			compare_field("final_of_run", 32'(ev.last_of_run), 32'(last));
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic               operation    = OP_SAMPLE;
	logic [4:0]         buttons      = '0;
	logic signed [15:0] pos_x        = '0;
	logic signed [15:0] pos_y        = '0;
	logic [31:0]        stamp_ms     = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [1:0]         event_kind;
	logic [4:0]         out_buttons;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [31:0]        out_ms;
	logic               final_of_run;
	logic               cfg_we       = 1'b0;
	logic [1:0]         cfg_index    = '0;
	logic [15:0]        cfg_data     = '0;

	event_forecast      forecast = new();
	int                 send_gap_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 items_sent = 0;
	logic signed [15:0] cur_x = '0;
	logic signed [15:0] cur_y = '0;
	logic [31:0]        cur_ms = 32'd5000;
	logic [4:0]         last_held = 5'd1;

	pointer_event_cooker_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.buttons      (buttons),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.stamp_ms     (stamp_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.out_buttons  (out_buttons),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_ms       (out_ms),
		.final_of_run (final_of_run),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("FAIL");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			forecast.check_event(event_kind, out_buttons, out_x, out_y, out_ms, final_of_run);
	end

	// Entered and left at a falling edge; valid stays high between back-to-back items.
	task automatic send_item(input logic op, input logic [4:0] b, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic [31:0] ms);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		buttons   <= b;
		pos_x     <= x;
		pos_y     <= y;
		stamp_ms  <= ms;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		forecast.absorb_item(op, b, x, y, ms);
		items_sent++;
		@(negedge clk);
	endtask

	// Fields of a tick are ignored by the block, so they carry noise.
	task automatic send_tick();
		send_item(OP_TICK, 5'($urandom), 16'($urandom), 16'($urandom), $urandom);
	endtask

	task automatic send_sample(input logic [4:0] b);
		send_item(OP_SAMPLE, b, cur_x, cur_y, cur_ms);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		forecast.set_reg(index, data);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [15:0] window, input logic [3:0] quiet,
			input logic [15:0] tick);
		write_reg(REG_DOUBLE_WINDOW, window);
		write_reg(REG_QUIET_TICKS, {12'($urandom), quiet});
		write_reg(REG_TICK_MS, tick);
		write_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Holds the sender off until every predicted event has come out, then
	// lets the block settle in case a silent item is still in flight.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (forecast.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic advance_time();
		if ($urandom_range(0, 3) == 0)
			cur_ms = cur_ms + $urandom_range(0, 70000);
		else
			cur_ms = cur_ms + $urandom_range(0, 400);
	endtask

	task automatic move_pointer();
		if ($urandom_range(0, 19) == 0) begin
			cur_x = 16'($urandom);
			cur_y = 16'($urandom);
		end else begin
			cur_x = cur_x + 16'($urandom_range(0, 8)) - 16'd4;
			cur_y = cur_y + 16'($urandom_range(0, 8)) - 16'd4;
		end
	endtask

	// Press, drag, perhaps switch to a disjoint set, then release.
	task automatic gesture();
		logic [4:0] held;
		logic [4:0] other;
		int         moves;
		held = ($urandom_range(0, 2) == 0) ? last_held : 5'($urandom_range(1, 31));
		last_held = held;
		advance_time();
		send_sample(held);
		moves = $urandom_range(0, 4);
		for (int i = 0; i < moves; i++) begin
			advance_time();
			move_pointer();
			if ($urandom_range(0, 4) == 0)
				send_tick();
			send_sample(held);
		end
		if ($urandom_range(0, 3) == 0) begin
			other = ~held & 5'($urandom_range(1, 31));
			if (other != 0) begin
				held = other;
				advance_time();
				move_pointer();
				send_sample(held);
			end
		end
		if ($urandom_range(0, 4) == 0)
			send_sample(held);
		advance_time();
		if ($urandom_range(0, 1) == 0)
			move_pointer();
		send_sample(5'd0);
	endtask

	task automatic idle_run();
		int ticks;
		if ($urandom_range(0, 1) == 0) begin
			advance_time();
			move_pointer();
			send_sample(5'd0);
		end
		ticks = $urandom_range(1, 20);
		for (int i = 0; i < ticks; i++)
			send_tick();
	endtask

	task automatic random_traffic(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gesture();
				6, 7: idle_run();
				8: send_item(1'($urandom), 5'($urandom), 16'($urandom), 16'($urandom), $urandom);
				default: begin
					cur_ms = $urandom;
					cur_x  = 16'($urandom);
					cur_y  = 16'($urandom);
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset register values.
		// A zero sample equals the reset state: dropped, and it stops quiet events.
		send_item(OP_SAMPLE, 5'd0, 16'sd0, 16'sd0, 32'd100);
		send_tick();
		send_tick();
		send_item(OP_SAMPLE, 5'd1, 16'sh7FFF, 16'sh8000, 32'd1000);
		send_tick();
		send_item(OP_SAMPLE, 5'd1, 16'sh8000, 16'sh7FFF, 32'd1010);
		send_item(OP_SAMPLE, 5'd0, 16'sh8000, 16'sh7FFF, 32'd1100);
		// Same button set again inside the window: double click.
		send_item(OP_SAMPLE, 5'd1, 16'sh8000, 16'sh7FFF, 32'd1300);
		send_item(OP_SAMPLE, 5'd1, 16'sd10, 16'sd20, 32'd1350);
		// Disjoint set: release copy first, double flag still carried.
		send_item(OP_SAMPLE, 5'd6, 16'sd11, 16'sd21, 32'd1400);
		send_item(OP_SAMPLE, 5'd0, 16'sd11, 16'sd21, 32'd1500);
		// Fourth idle tick exceeds the limit; the fifth finds quiet already sent.
		repeat (5) send_tick();
		// Press interval across the wrap of the millisecond counter.
		send_item(OP_SAMPLE, 5'd31, -16'sd1, -16'sd1, 32'hFFFF_FFF0);
		send_item(OP_SAMPLE, 5'd0, -16'sd1, -16'sd1, 32'hFFFF_FFF8);
		send_item(OP_SAMPLE, 5'd31, -16'sd1, -16'sd1, 32'h0000_0010);
		send_item(OP_SAMPLE, 5'd31, -16'sd1, -16'sd1, 32'h0000_0018);
		send_item(OP_SAMPLE, 5'd0, -16'sd1, -16'sd1, 32'h0000_0020);
		send_item(OP_SAMPLE, 5'd16, 16'sd0, 16'sd0, 32'h0000_0000);
		send_item(OP_SAMPLE, 5'd0, 16'sd0, 16'sd0, 32'h0000_0000);
		send_tick();
		send_tick();
		send_item(OP_SAMPLE, 5'd0, 16'sd5, 16'sd5, 32'h7FFF_FFFF);
		wait_drained();

		for (int half = 0; half < HALVES; half++) begin
			case (half / 2)
				0: begin
					send_gap_pct   = 12;
					recv_stall_pct = 81;
				end
				1: begin
					send_gap_pct   = 81;
					recv_stall_pct = 12;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			case (half)
				0: set_regs(16'hFFFF, 4'd15, 16'hFFFF);
				1: set_regs(16'h0000, 4'd0, 16'h0000);
				2: set_regs(16'($urandom_range(100, 2000)), 4'($urandom), 16'($urandom));
				3: set_regs(16'd500, 4'd3, 16'd500);
				4: set_regs(16'($urandom), 4'($urandom_range(0, 4)), 16'($urandom));
				default: set_regs(16'hFFFF, 4'd0, 16'hFFFF);
			endcase
			random_traffic(HALF_ITEMS);
			wait_drained();
		end

		if (forecast.errors == 0 && forecast.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
